/* design/ray_square_pick_macros.svh */
// Assertion shorthands for the pick block; clock clk, reset arst_n.
`ifndef RAY_SQUARE_PICK_MACROS_SVH
`define RAY_SQUARE_PICK_MACROS_SVH

// Same-cycle implication.
`define RSP_HOLDS(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define RSP_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* design/rsp_pkg.sv */
package rsp_pkg;

	localparam int COORD_W = 32;
	localparam int DIR_W   = 16;
	localparam int HALF_W  = 20;
	localparam int TRI_W   = 2;

	localparam int DIFF_W  = COORD_W + 1;
	localparam int OFF_W   = COORD_W + 2;
	localparam int PROD_W  = OFF_W + DIR_W;
	localparam int BARY_W  = PROD_W + 1;
	localparam int CORR_W  = BARY_W + 1;
	localparam int SUM_W   = CORR_W + 1;
	localparam int DET_W   = HALF_W + 2 + DIR_W;

	localparam logic [HALF_W-1:0] HALF_RESET = 20'd204800;

	localparam logic [TRI_W-1:0] TRI_NONE   = 2'd0;
	localparam logic [TRI_W-1:0] TRI_FIRST  = 2'd1;
	localparam logic [TRI_W-1:0] TRI_SECOND = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [DIR_W-1:0]   dir_x;
		logic signed [DIR_W-1:0]   dir_y;
		logic signed [DIR_W-1:0]   dir_z;
	} in_beat_t;

	typedef struct packed {
		logic             hit;
		logic [TRI_W-1:0] which_triangle;
	} out_beat_t;

endpackage

/* design/ray_square_pick.sv */
// Ray pick against a horizontal square split into two triangles. One ray beat is
// taken per clock while in_stall is low, and its answer passes through the
// five-stage arithmetic pipeline (offsets, products, barycentric numerators, sign
// correction, bounds test) before it is valid on out_data.
// in_stall rises only when all five stages hold a beat and out_stall holds the
// result. half_size is to be loaded by the user through cfg_we/cfg_wdata while
// no beat is in flight, which the block does not enforce; it resets to 50.0 in Q8.12.
module ray_square_pick (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rsp_pkg::HALF_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rsp_pkg::in_beat_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rsp_pkg::out_beat_t                  out_data
);

	localparam int DW = rsp_pkg::DIFF_W;
	localparam int OW = rsp_pkg::OFF_W;
	localparam int PW = rsp_pkg::PROD_W;
	localparam int BW = rsp_pkg::BARY_W;
	localparam int CW = rsp_pkg::CORR_W;
	localparam int SW = rsp_pkg::SUM_W;
	localparam int EW = rsp_pkg::DET_W;
	localparam int HW = rsp_pkg::HALF_W;
	localparam int RW = rsp_pkg::DIR_W;

	logic [HW-1:0] half_size_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	// stage 1
	logic signed [OW-1:0] tx1_s1, tx2_s1, tz1_s1, tz2_s1;
	logic signed [DW-1:0] ty_s1;
	logic signed [RW-1:0] dx_s1, dy_s1, dz_s1;
	// stage 2
	logic signed [PW-1:0] pa_s2, pb_s2, px1_s2, px2_s2, pz1_s2, pz2_s2;
	logic signed [EW-1:0] det_s2;
	// stage 3
	logic signed [BW-1:0] u1_s3, v1_s3, u2_s3, v2_s3;
	logic signed [EW-1:0] det_s3;
	// stage 4
	logic signed [CW-1:0] cu1_s4, cv1_s4, cu2_s4, cv2_s4;
	logic signed [EW-1:0] mag_s4;
	logic                 nz_s4;
	// stage 5
	rsp_pkg::out_beat_t   res_s5;

	logic signed [DW-1:0] dif_x, dif_y, dif_z;
	logic signed [OW-1:0] h_ext;
	logic signed [HW+1:0] e_ext;
	logic signed [SW-1:0] mag_ext, sum1, sum2;
	logic                 hit1, hit2;

	assign en5 = !v_s5 || !out_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= rsp_pkg::HALF_RESET;
		end else if (cfg_we) begin
			half_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		dif_x = $signed({in_data.origin_x[31], in_data.origin_x})
			- $signed({in_data.center_x[31], in_data.center_x});
		dif_y = $signed({in_data.origin_y[31], in_data.origin_y})
			- $signed({in_data.center_y[31], in_data.center_y});
		dif_z = $signed({in_data.origin_z[31], in_data.origin_z})
			- $signed({in_data.center_z[31], in_data.center_z});
		h_ext = $signed({(OW-HW)'(0), half_size_q});
		e_ext = $signed({1'b0, half_size_q, 1'b0});
	end

	// offsets from the triangle corners
	always_ff @(posedge clk) begin
		if (en1) begin
			tx1_s1 <= OW'(dif_x) + h_ext;
			tx2_s1 <= OW'(dif_x) - h_ext;
			tz1_s1 <= OW'(dif_z) - h_ext;
			tz2_s1 <= OW'(dif_z) + h_ext;
			ty_s1  <= dif_y;
			dx_s1  <= in_data.dir_x;
			dy_s1  <= in_data.dir_y;
			dz_s1  <= in_data.dir_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pa_s2  <= PW'(ty_s1 * dx_s1);
			pb_s2  <= PW'(ty_s1 * dz_s1);
			px1_s2 <= PW'(tx1_s1 * dy_s1);
			px2_s2 <= PW'(tx2_s1 * dy_s1);
			pz1_s2 <= PW'(tz1_s1 * dy_s1);
			pz2_s2 <= PW'(tz2_s1 * dy_s1);
			det_s2 <= EW'(e_ext * dy_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			u1_s3  <= BW'(pa_s2) - BW'(px1_s2);
			v1_s3  <= BW'(pz1_s2) - BW'(pb_s2);
			u2_s3  <= BW'(pz2_s2) - BW'(pb_s2);
			v2_s3  <= BW'(pa_s2) - BW'(px2_s2);
			det_s3 <= det_s2;
		end
	end

	// first triangle's determinant is -det, second's is +det: flip to make it positive
	always_ff @(posedge clk) begin
		if (en4) begin
			cu1_s4 <= det_s3[EW-1] ? CW'(u1_s3) : -CW'(u1_s3);
			cv1_s4 <= det_s3[EW-1] ? CW'(v1_s3) : -CW'(v1_s3);
			cu2_s4 <= det_s3[EW-1] ? -CW'(u2_s3) : CW'(u2_s3);
			cv2_s4 <= det_s3[EW-1] ? -CW'(v2_s3) : CW'(v2_s3);
			mag_s4 <= det_s3[EW-1] ? -det_s3 : det_s3;
			nz_s4  <= det_s3 != '0;
		end
	end

	always_comb begin
		mag_ext = SW'(mag_s4);
		sum1 = SW'(cu1_s4) + SW'(cv1_s4);
		sum2 = SW'(cu2_s4) + SW'(cv2_s4);
		hit1 = nz_s4 && !cu1_s4[CW-1] && !cv1_s4[CW-1]
			&& (SW'(cu1_s4) <= mag_ext) && (sum1 <= mag_ext);
		hit2 = nz_s4 && !cu2_s4[CW-1] && !cv2_s4[CW-1]
			&& (SW'(cu2_s4) <= mag_ext) && (sum2 <= mag_ext);
	end

	// first triangle wins a tie
	always_ff @(posedge clk) begin
		if (en5) begin
			res_s5.hit <= hit1 || hit2;
			if (hit1) begin
				res_s5.which_triangle <= rsp_pkg::TRI_FIRST;
			end else if (hit2) begin
				res_s5.which_triangle <= rsp_pkg::TRI_SECOND;
			end else begin
				res_s5.which_triangle <= rsp_pkg::TRI_NONE;
			end
		end
	end

	assign out_valid = v_s5;
	assign out_data  = res_s5;

endmodule

/* design/rsp_checker.sv */
`include "ray_square_pick_macros.svh"

module rsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input rsp_pkg::out_beat_t out_data
);

	`RSP_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

	`RSP_HOLDS(a_stall_back, in_stall, out_valid && out_stall, "input stalled while output drains")

	`RSP_HOLDS(a_hit_tri, out_valid, out_data.hit == (out_data.which_triangle != rsp_pkg::TRI_NONE), "hit and triangle disagree")

	`RSP_HOLDS(a_tri_code, out_valid, (out_data.which_triangle == rsp_pkg::TRI_NONE) || (out_data.which_triangle == rsp_pkg::TRI_FIRST) || (out_data.which_triangle == rsp_pkg::TRI_SECOND), "triangle code out of range")

endmodule

bind ray_square_pick rsp_checker u_rsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* bench/tb.sv */
module tb;

	localparam int QUIET_LIMIT = 4000;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rsp_pkg::HALF_W-1:0] cfg_wdata = rsp_pkg::HALF_RESET;
	logic in_valid = 1'b0;
	logic in_stall;
	rsp_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_pkg::out_beat_t out_data;

	rsp_pkg::out_beat_t picks_due[$];
	logic [rsp_pkg::HALF_W-1:0] half_now = rsp_pkg::HALF_RESET;
	bit steady = 1'b0;
	int stall_left = 0;
	int quiet = 0;
	int mismatches = 0;

	ray_square_pick dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit in_triangle(longint d, longint u, longint v);
		if (d == 0)
			return 1'b0;
		if (d < 0) begin
			d = -d;
			u = -u;
			v = -v;
		end
		return u >= 0 && u <= d && v >= 0 && u + v <= d;
	endfunction

	function automatic rsp_pkg::out_beat_t pick_square(rsp_pkg::in_beat_t r,
			logic [rsp_pkg::HALF_W-1:0] hs);
		longint h, e, cx, cy, cz, ox, oy, oz, dx, dy, dz, tx, ty, tz;
		rsp_pkg::out_beat_t res;
		h = hs;
		e = 2 * h;
		cx = r.center_x;
		cy = r.center_y;
		cz = r.center_z;
		ox = r.origin_x;
		oy = r.origin_y;
		oz = r.origin_z;
		dx = r.dir_x;
		dy = r.dir_y;
		dz = r.dir_z;
		ty = oy - cy;
		res.which_triangle = rsp_pkg::TRI_NONE;
		tx = ox - (cx - h);
		tz = oz - (cz + h);
		if (in_triangle(-e * dy, dx * ty - dy * tx, dy * tz - dz * ty)) begin
			res.which_triangle = rsp_pkg::TRI_FIRST;
		end else begin
			tx = ox - (cx + h);
			tz = oz - (cz - h);
			if (in_triangle(e * dy, dy * tz - dz * ty, dx * ty - dy * tx))
				res.which_triangle = rsp_pkg::TRI_SECOND;
		end
		res.hit = (res.which_triangle != rsp_pkg::TRI_NONE);
		return res;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint spread(longint lim);
		return longint'($urandom_range(0, int'(2 * lim))) - lim;
	endfunction

	function automatic longint coord_near();
		logic signed [rsp_pkg::COORD_W-1:0] w;
		w = $urandom;
		return w >>> 1;
	endfunction

	function automatic longint dir_pick();
		logic signed [rsp_pkg::DIR_W-1:0] w;
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return spread(8);
		if (r < 3)
			return $urandom_range(0, 1) ? 32767 : -32768;
		w = (rsp_pkg::DIR_W)'($urandom);
		return w;
	endfunction

	function automatic rsp_pkg::in_beat_t aim_at(longint cx, longint cy, longint cz,
			longint px, longint pz, longint dx, longint dy, longint dz, longint k);
		rsp_pkg::in_beat_t r;
		r.center_x = (rsp_pkg::COORD_W)'(cx);
		r.center_y = (rsp_pkg::COORD_W)'(cy);
		r.center_z = (rsp_pkg::COORD_W)'(cz);
		r.origin_x = (rsp_pkg::COORD_W)'(cx + px - k * dx);
		r.origin_y = (rsp_pkg::COORD_W)'(cy - k * dy);
		r.origin_z = (rsp_pkg::COORD_W)'(cz + pz - k * dz);
		r.dir_x = (rsp_pkg::DIR_W)'(dx);
		r.dir_y = (rsp_pkg::DIR_W)'(dy);
		r.dir_z = (rsp_pkg::DIR_W)'(dz);
		return r;
	endfunction

	function automatic rsp_pkg::in_beat_t aimed_ray(logic [rsp_pkg::HALF_W-1:0] hs);
		longint h, lim, px, pz, dy;
		int sel;
		h = hs;
		lim = h + h / 4 + 1;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			px = spread(lim);
			pz = spread(lim);
		end else if (sel < 60) begin
			px = $urandom_range(0, 1) ? h : -h;
			pz = spread(h);
		end else if (sel < 75) begin
			pz = $urandom_range(0, 1) ? h : -h;
			px = spread(h);
		end else if (sel < 88) begin
			px = spread(lim);
			pz = $urandom_range(0, 1) ? px : -px;
		end else begin
			px = ($urandom_range(0, 1) ? h : -h) + spread($urandom_range(0, 1));
			pz = ($urandom_range(0, 1) ? h : -h) + spread($urandom_range(0, 1));
		end
		dy = ($urandom_range(0, 11) == 0) ? 0 : dir_pick();
		return aim_at(coord_near(), coord_near(), coord_near(), px, pz,
			dir_pick(), dy, dir_pick(), $urandom_range(0, 1023));
	endfunction

	function automatic rsp_pkg::in_beat_t random_ray(logic [rsp_pkg::HALF_W-1:0] hs);
		if ($urandom_range(0, 99) < 78)
			return aimed_ray(hs);
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			16'($urandom)};
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic send_ray(input rsp_pkg::in_beat_t r);
		int gap;
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		picks_due = {picks_due, pick_square(r, half_now)};
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (picks_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_half_size(input logic [rsp_pkg::HALF_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		half_now = v;
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				steady = ($urandom_range(0, 4) == 0);
			send_ray(random_ray(half_now));
		end
		steady = 1'b0;
	endtask

	task automatic test_border_cases();
		longint h, cx, cy, cz;
		h = half_now;
		cx = -1000000;
		cy = 123456;
		cz = 777777;
		send_ray(aim_at(0, 0, 0, 0, 0, 0, -16384, 0, 10));
		send_ray(aim_at(0, 0, 0, -h / 2, h / 2, 0, -16384, 0, 10));
		send_ray(aim_at(0, 0, 0, h / 2, -h / 2, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, h, h, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, -h, -h, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, -h, h, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, h, -h, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, h, 0, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, 0, h, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, -h, 0, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, 0, -h, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, h + 1, 0, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, 0, -h - 1, 0, -16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, h / 2, -h / 2, 0, 16384, 0, 10));
		send_ray(aim_at(cx, cy, cz, -h / 3, h / 4, 3000, -5000, -7000, 37));
		send_ray(aim_at(cx, cy, cz, 0, 0, 16384, 0, 0, 10));
	endtask

	task automatic test_field_extremes();
		send_ray(rsp_pkg::in_beat_t'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff});
		send_ray(rsp_pkg::in_beat_t'{32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000});
		send_ray('0);
		send_ray('1);
		send_ray(rsp_pkg::in_beat_t'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 16'h7fff, 16'h8000, 16'h7fff});
		send_ray(rsp_pkg::in_beat_t'{32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h8000, 16'h7fff, 16'h8000});
	endtask

	task automatic test_size_extremes();
		set_half_size(20'd1);
		run_random(180);
		set_half_size(20'hfffff);
		run_random(180);
	endtask

	task automatic test_random_sizes();
		set_half_size(rsp_pkg::HALF_RESET);
		run_random(270);
		set_half_size((rsp_pkg::HALF_W)'($urandom_range(1, 64)));
		run_random(270);
		set_half_size((rsp_pkg::HALF_W)'($urandom_range(1, 20'hfffff)));
		run_random(270);
		set_half_size((rsp_pkg::HALF_W)'($urandom_range(1, 20'hfffff)));
		run_random(270);
	endtask

	always @(negedge clk) begin
		if (!arst_n || steady)
			stall_left = 0;
		else if (stall_left > 0)
			stall_left--;
		else if ($urandom_range(0, 3) == 0)
			stall_left = pause_len() + 1;
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		rsp_pkg::out_beat_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (picks_due.size() == 0) begin
				report_mismatch("result beat with no ray outstanding");
			end else begin
				want = picks_due.pop_front();
				if (out_data.hit !== want.hit)
					report_mismatch($sformatf("hit %b, want %b", out_data.hit, want.hit));
				if (out_data.which_triangle !== want.which_triangle)
					report_mismatch($sformatf("which_triangle %0d, want %0d",
						out_data.which_triangle, want.which_triangle));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_border_cases();
		test_field_extremes();
		test_size_extremes();
		test_random_sizes();
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* sim.f */
+incdir+design
design/rsp_pkg.sv
design/ray_square_pick.sv
design/rsp_checker.sv
bench/tb.sv
